[design/mfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mfr_pkg;

  localparam int PANEL_WIDTH  = 480;
  localparam int PANEL_HEIGHT = 640;
  localparam int ROW_STRIDE   = PANEL_HEIGHT / 8;
  localparam int FRAME_DEPTH  = ROW_STRIDE * PANEL_WIDTH;

  localparam int FADDR_W = $clog2(FRAME_DEPTH);
  localparam int SROW_W  = $clog2(PANEL_WIDTH);
  localparam int SCOL_W  = $clog2(PANEL_HEIGHT);
  localparam int PCOL_W  = 9;

  localparam logic [15:0] PIX_BLACK = 16'h0000;
  localparam logic [15:0] PIX_WHITE = 16'hFFFF;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  localparam logic CFG_ROTATE = 1'b0;
  localparam logic CFG_SOURCE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] frame_address;
    logic [7:0]  frame_byte;
    logic [9:0]  panel_row;
    logic [7:0]  pair_slot;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_even;
    logic [15:0] pixel_odd;
    logic        filled;
  } out_item_t;

  // how to turn the two fetched bytes into pixels
  typedef struct packed {
    logic       filled;
    logic       even_ok;
    logic       odd_ok;
    logic [2:0] bit_idx;
  } pick_t;

endpackage
`default_nettype wire

[design/mfr_frame_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module mfr_frame_ram (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [mfr_pkg::FADDR_W-1:0] wr_addr,
  input  wire logic [7:0]                  wr_data,
  input  wire logic                        rd_en,
  input  wire logic [mfr_pkg::FADDR_W-1:0] rd_addr_a,
  input  wire logic [mfr_pkg::FADDR_W-1:0] rd_addr_b,
  output logic      [7:0]                  rd_data_a,
  output logic      [7:0]                  rd_data_b
);
  import mfr_pkg::*;

  logic [7:0] mem [FRAME_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

[design/mfr_addr_map.sv]
`timescale 1ns / 1ps
`default_nettype none
module mfr_addr_map (
  input  wire logic                        rotate_half_turn,
  input  wire logic                        source_enabled,
  input  wire logic [9:0]                  panel_row,
  input  wire logic [7:0]                  pair_slot,
  output logic      [mfr_pkg::FADDR_W-1:0] addr_even,
  output logic      [mfr_pkg::FADDR_W-1:0] addr_odd,
  output mfr_pkg::pick_t                   pick
);
  import mfr_pkg::*;

  logic [PCOL_W-1:0] pcol_even;
  logic [PCOL_W-1:0] pcol_odd;
  logic              row_ok;
  logic              even_ok;
  logic              odd_ok;
  logic [SCOL_W-1:0] scol;
  logic [SROW_W-1:0] srow_even;
  logic [SROW_W-1:0] srow_odd;
  logic [FADDR_W-1:0] byte_col;

  always_comb begin
    pcol_even = {pair_slot, 1'b0};
    pcol_odd  = {pair_slot, 1'b1};
    row_ok    = 32'(panel_row) < PANEL_HEIGHT;
    even_ok   = row_ok && (32'(pcol_even) < PANEL_WIDTH);
    odd_ok    = row_ok && (32'(pcol_odd) < PANEL_WIDTH);

    if (rotate_half_turn) begin
      scol      = SCOL_W'(PANEL_HEIGHT - 1) - SCOL_W'(panel_row);
      srow_even = SROW_W'(pcol_even);
      srow_odd  = SROW_W'(pcol_odd);
    end else begin
      scol      = SCOL_W'(panel_row);
      srow_even = SROW_W'(PANEL_WIDTH - 1) - SROW_W'(pcol_even);
      srow_odd  = SROW_W'(PANEL_WIDTH - 1) - SROW_W'(pcol_odd);
    end

    byte_col = FADDR_W'(scol >> 3);
    // out-of-panel pixels read entry zero and are forced white later when the source is enabled
    addr_even = even_ok ?
      FADDR_W'(FADDR_W'(srow_even) * FADDR_W'(ROW_STRIDE)) + byte_col : '0;
    addr_odd  = odd_ok ?
      FADDR_W'(FADDR_W'(srow_odd) * FADDR_W'(ROW_STRIDE)) + byte_col : '0;

    pick.filled  = source_enabled;
    pick.even_ok = even_ok;
    pick.odd_ok  = odd_ok;
    pick.bit_idx = ~scol[2:0];
  end

endmodule
`default_nettype wire

[design/mono_frame_rotate_to_rgb565.sv]
`timescale 1ns / 1ps
`default_nettype none
// output path: an accepted fetch request reaches the output through the memory read
// register and then the output register
// throughput: one request per cycle unless in_stall is high, writes and fetches mixed,
// set by the two read ports plus one write port of the frame memory
// reset: clears the pipeline valids and both config registers; the frame
// memory is not cleared and holds whatever was written
module mono_frame_rotate_to_rgb565 (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mfr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mfr_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic               cfg_data
);
  import mfr_pkg::*;

  logic               rotate_half_turn;
  logic               source_enabled;
  logic               accept;
  logic               s1_advance;
  logic               s1_valid;
  pick_t              s1_pick;
  pick_t              pick_next;
  logic [FADDR_W-1:0] addr_even;
  logic [FADDR_W-1:0] addr_odd;
  logic [7:0]         byte_even;
  logic [7:0]         byte_odd;
  logic               wr_en;
  logic               rd_en;
  out_item_t          out_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_half_turn <= 1'b0;
      source_enabled   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROTATE: rotate_half_turn <= cfg_data;
        CFG_SOURCE: source_enabled   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !s1_advance;
  assign accept     = in_valid && !in_stall;
  assign wr_en      = accept && (in_data.func == FUNC_WRITE) &&
                      (32'(in_data.frame_address) < FRAME_DEPTH);
  assign rd_en      = accept && (in_data.func == FUNC_FETCH);

  mfr_addr_map u_addr_map (
    .rotate_half_turn (rotate_half_turn),
    .source_enabled   (source_enabled),
    .panel_row        (in_data.panel_row),
    .pair_slot        (in_data.pair_slot),
    .addr_even        (addr_even),
    .addr_odd         (addr_odd),
    .pick             (pick_next)
  );

  // write and read both land at the accept edge, so a fetch right after a
  // write to the same byte already sees it
  mfr_frame_ram u_frame_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (FADDR_W'(in_data.frame_address)),
    .wr_data   (in_data.frame_byte),
    .rd_en     (rd_en),
    .rd_addr_a (addr_even),
    .rd_addr_b (addr_odd),
    .rd_data_a (byte_even),
    .rd_data_b (byte_odd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= (in_data.func == FUNC_FETCH);
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_pick <= pick_next;
    end
  end

  always_comb begin
    if (!s1_pick.filled) begin
      out_next.pixel_even = PIX_BLACK;
      out_next.pixel_odd  = PIX_BLACK;
      out_next.filled     = 1'b0;
    end else begin
      out_next.pixel_even = (s1_pick.even_ok && byte_even[s1_pick.bit_idx]) ?
                            PIX_BLACK : PIX_WHITE;
      out_next.pixel_odd  = (s1_pick.odd_ok && byte_odd[s1_pick.bit_idx]) ?
                            PIX_BLACK : PIX_WHITE;
      out_next.filled     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      out_data <= out_next;
    end
  end

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.func == FUNC_WRITE) |=> !s1_valid)
    else $error("write request produced a pipeline entry");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked output");

  a_unfilled_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.filled) |->
      (out_data.pixel_even == PIX_BLACK && out_data.pixel_odd == PIX_BLACK))
    else $error("unfilled result carries nonzero pixels");

  a_filled_mono: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.filled) |->
      ((out_data.pixel_even == PIX_BLACK || out_data.pixel_even == PIX_WHITE) &&
       (out_data.pixel_odd == PIX_BLACK || out_data.pixel_odd == PIX_WHITE)))
    else $error("filled pixel is neither black nor white");

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import mfr_pkg::*;

  localparam int LIMIT      = 400000;
  localparam int LONG_HOLD  = 300;
  localparam int PHASES     = 6;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = 1'b0;
  logic      cfg_data = 1'b0;

  mono_frame_rotate_to_rgb565 dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state: frame copy and register copy
  logic [7:0] frame_mem [FRAME_DEPTH];
  logic       rot_setting = 1'b0;
  logic       source_on = 1'b0;
  out_item_t  pixel_pairs_due [$];

  // stimulus planning
  in_item_t   requests_to_send [$];
  bit         frame_written [FRAME_DEPTH];
  int         written_list [$];
  int         queued = 0;
  int         win_row = 0;
  int         win_slot = 0;
  bit         no_idle = 1'b0;
  int         long_hold_asks = 0;
  int         long_hold_seen = 0;

  int         gap_left = 0;
  int         stall_left = 0;
  int         errors = 0;
  int         cycles = 0;
  int         n_writes = 0;
  int         n_fetches = 0;
  int         n_off = 0;
  int         n_reg_writes = 0;

  int edge_rows [4] = '{0, 639, 640, 1023};
  int edge_slots [4] = '{0, 239, 240, 255};
  logic [1:0] phase_cfg [PHASES] = '{2'b01, 2'b11, 2'b10, 2'b01, 2'b11, 2'b00};

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // frame byte and bit behind a panel pixel, -1 when outside the panel
  function automatic int locate(input logic rot, input int prow, input int pcol,
                                output int bit_pos);
    int scol, srow;
    bit_pos = 0;
    if (prow >= PANEL_HEIGHT || pcol >= PANEL_WIDTH) return -1;
    if (rot) begin
      scol = PANEL_HEIGHT - 1 - prow;
      srow = pcol;
    end else begin
      scol = prow;
      srow = PANEL_WIDTH - 1 - pcol;
    end
    bit_pos = 7 - scol % 8;
    return srow * ROW_STRIDE + scol / 8;
  endfunction

  function automatic logic [15:0] panel_pixel(input int prow, input int pcol);
    int idx, bit_pos;
    idx = locate(rot_setting, prow, pcol, bit_pos);
    if (idx < 0) return PIX_WHITE;
    return frame_mem[idx][bit_pos] ? PIX_BLACK : PIX_WHITE;
  endfunction

  task automatic apply_request(input in_item_t r);
    out_item_t want;
    if (r.func == FUNC_WRITE) begin
      if (r.frame_address < FRAME_DEPTH) frame_mem[r.frame_address] = r.frame_byte;
      n_writes++;
      return;
    end
    n_fetches++;
    if (!source_on) begin
      want = '0;
      n_off++;
    end else begin
      want.pixel_even = panel_pixel(r.panel_row, 2 * r.pair_slot);
      want.pixel_odd  = panel_pixel(r.panel_row, 2 * r.pair_slot + 1);
      want.filled     = 1'b1;
    end
    pixel_pairs_due.push_back(want);
  endtask

  task automatic check_pixel_pair(input out_item_t got);
    out_item_t want;
    if (pixel_pairs_due.size() == 0) begin
      report_error($sformatf("pixel pair with no fetch pending: %h", got));
      return;
    end
    want = pixel_pairs_due.pop_front();
    if (got.pixel_even !== want.pixel_even || got.pixel_odd !== want.pixel_odd ||
        got.filled !== want.filled)
      report_error($sformatf("got even %h odd %h filled %b, want even %h odd %h filled %b",
                             got.pixel_even, got.pixel_odd, got.filled,
                             want.pixel_even, want.pixel_odd, want.filled));
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_request(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (requests_to_send.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= requests_to_send.pop_front();
          if (!no_idle && $urandom_range(0, 2) == 0) gap_left = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_pixel_pair(out_data);
      if (long_hold_asks != long_hold_seen) begin
        long_hold_seen = long_hold_asks;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("timeout with %0d pixel pairs outstanding", pixel_pairs_due.size());
      $display("mono_frame_rotate_to_rgb565 test failed");
      $finish;
    end
  end

  function automatic in_item_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  task automatic put_write(input int addr, input logic [7:0] data);
    in_item_t r;
    r = random_item();
    r.func = FUNC_WRITE;
    r.frame_address = 16'(addr);
    r.frame_byte = data;
    requests_to_send.push_back(r);
    if (addr < FRAME_DEPTH) begin
      queued++;
      if (!frame_written[addr]) begin
        frame_written[addr] = 1'b1;
        written_list.push_back(addr);
      end
    end
  endtask

  // a fetch never reads a byte that has not been stored first
  task automatic put_fetch(input int prow, input int slot);
    in_item_t r;
    int idx, bit_pos;
    for (int c = 0; c < 2; c++) begin
      idx = locate(rot_setting, prow, 2 * slot + c, bit_pos);
      if (idx >= 0 && !frame_written[idx]) put_write(idx, 8'($urandom_range(0, 255)));
    end
    r = random_item();
    r.func = FUNC_FETCH;
    r.panel_row = 10'(prow);
    r.pair_slot = 8'(slot);
    requests_to_send.push_back(r);
    queued++;
  endtask

  task automatic fill_random(input int count);
    int stop, pick;
    stop = queued + count;
    while (queued < stop) begin
      if ($urandom_range(0, 19) == 0) begin
        win_row = $urandom_range(0, 630);
        win_slot = $urandom_range(0, 236);
      end
      pick = $urandom_range(0, 99);
      // fetches mostly stay in a small window so stored bytes get read back often
      if (pick < 55)
        put_fetch(win_row + $urandom_range(0, 15), win_slot + $urandom_range(0, 7));
      else if (pick < 70)
        put_fetch($urandom_range(0, 1023), $urandom_range(0, 255));
      else if (pick < 82 && written_list.size() != 0)
        put_write(written_list[$urandom_range(0, written_list.size() - 1)],
                  8'($urandom_range(0, 255)));
      else if (pick < 92)
        put_write($urandom_range(0, FRAME_DEPTH - 1), 8'($urandom_range(0, 255)));
      else if (pick < 96)
        put_write($urandom_range(0, 65535), 8'($urandom_range(0, 255)));
      else
        put_fetch(edge_rows[$urandom_range(0, 3)], edge_slots[$urandom_range(0, 3)]);
    end
  endtask

  // wait for every request to go in and every pixel pair to come out,
  // then wait on for trailing writes
  task automatic drain();
    do @(posedge clk);
    while (requests_to_send.size() != 0 || in_valid || pixel_pairs_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROTATE) rot_setting = val;
    else source_on = val;
    n_reg_writes++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // source off after reset: fetches come back empty
    put_write(0, 8'hFF);
    put_fetch(0, 0);
    put_fetch(639, 239);
    drain();

    write_reg(CFG_SOURCE, 1'b1);
    // one dark and one lit pixel at the first panel pair
    put_write((PANEL_WIDTH - 1) * ROW_STRIDE, 8'h80);
    put_write((PANEL_WIDTH - 2) * ROW_STRIDE, 8'h7F);
    put_fetch(0, 0);
    put_fetch(639, 239);
    put_write(FRAME_DEPTH - 1, 8'hFF);
    put_write(FRAME_DEPTH, 8'h00);
    put_write(16'hFFFF, 8'hAA);
    put_fetch(639, 0);
    put_fetch(640, 5);
    put_fetch(1023, 255);
    put_fetch(100, 240);
    // overwrite then read back
    put_write((PANEL_WIDTH - 1) * ROW_STRIDE, 8'h00);
    put_fetch(0, 0);
    drain();

    write_reg(CFG_ROTATE, 1'b1);
    put_fetch(0, 0);
    put_fetch(639, 239);
    put_fetch(700, 3);
    put_fetch(320, 120);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(CFG_ROTATE, phase_cfg[p][1]);
      write_reg(CFG_SOURCE, phase_cfg[p][0]);
      no_idle = (p == 3 || p == 4);
      // long output hold while requests keep coming, so the input backs up
      if (p == 3) long_hold_asks++;
      fill_random(85);
    end

    drain();
    no_idle = 1'b0;
    repeat (8) @(posedge clk);
    $display("%0d fetches checked (%0d with the source off), %0d frame writes",
             n_fetches, n_off, n_writes);
    $display("%0d register writes over both orientations, one %0d-cycle output hold",
             n_reg_writes, LONG_HOLD);
    if (errors == 0) $display("mono_frame_rotate_to_rgb565 test passed");
    else $display("mono_frame_rotate_to_rgb565 test failed");
    $finish;
  end

endmodule
